// File: src/irsir_pkg.sv
// ----------------------------------------------------------------------------
// irsir_pkg
// Shared types, codes and reset values of the IrDA SIR half-duplex link.
// ----------------------------------------------------------------------------
package irsir_pkg;

    // Default depth of the send store and longest received message
    localparam int MSG_DEPTH_DEF = 32;

    // Fixed field widths
    localparam int LEN_W      = 6;
    localparam int TIME_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int FRAME_W    = 10;

    // Request codes
    typedef enum logic [1:0] {
        REQ_SEND    = 2'd0,
        REQ_RX_BYTE = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_TICK    = 2'd3
    } req_t;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_RISE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_RISE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_PERIOD  = 3'd5;

    // Register reset values (77, 102 and 204 times six timer counts)
    localparam logic [7:0]        END_BYTE_RST    = 8'd0;
    localparam logic [TIME_W-1:0] ZERO_RISE_RST   = 12'd462;
    localparam logic [TIME_W-1:0] ZERO_PERIOD_RST = 12'd612;
    localparam logic [TIME_W-1:0] ONE_RISE_RST    = 12'd1224;
    localparam logic [TIME_W-1:0] ONE_PERIOD_RST  = 12'd612;

endpackage

// File: src/irsir_ram.sv
// ----------------------------------------------------------------------------
// irsir_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module irsir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read (read returns old data on collision)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/irda_sir_half_duplex_link.sv
// ----------------------------------------------------------------------------
// irda_sir_half_duplex_link
// Half-duplex IrDA SIR link: send-message buffering, bit framing on timer
// ticks, received-byte delivery and message closing.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while s_ready is high and
// returns exactly one result per request, in the cycle after the transfer,
// from an output register; a new request is taken in the same cycle the
// waiting result is taken. Send bytes go to a MSG_DEPTH-entry store in a RAM.
// The store is read continuously at the next value of the send index, so the
// byte for the following bit tick is already in the read register; a write to
// that same entry in the same cycle is forwarded. Configuration writes take
// priority over requests: while cfg_valid is high no request is taken.
// ----------------------------------------------------------------------------
module irda_sir_half_duplex_link #(
    parameter int MSG_DEPTH = irsir_pkg::MSG_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [irsir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irsir_pkg::CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_req_type,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_last_byte,
    input  logic                             s_high_power,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic                             m_rx_byte_valid,
    output logic [7:0]                       m_rx_byte,
    output logic                             m_rx_msg_end,
    output logic [irsir_pkg::LEN_W-1:0]      m_rx_length,
    output logic                             m_bit_valid,
    output logic [irsir_pkg::TIME_W-1:0]     m_rise_offset,
    output logic [irsir_pkg::TIME_W-1:0]     m_bit_period,
    output logic                             m_tx_done,
    output logic                             m_boost_on,
    output logic                             m_tx_active
);

    localparam int AW     = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int CNT_W  = $clog2(MSG_DEPTH + 1);
    localparam int TW     = irsir_pkg::TIME_W;
    localparam int FW     = irsir_pkg::FRAME_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MSG_DEPTH);

    // Configuration registers
    logic [7:0]    end_byte_reg;
    logic          rx_enable_reg;
    logic [TW-1:0] zero_rise_reg, zero_period_reg, one_rise_reg, one_period_reg;

    // Link state
    logic [CNT_W-1:0] send_length_reg, send_length_next;
    logic [CNT_W-1:0] load_count_reg,  load_count_next;
    logic [CNT_W-1:0] send_index_reg,  send_index_next;
    logic [CNT_W-1:0] rx_count_reg,    rx_count_next;
    logic [FW-1:0]    frame_reg,       frame_next;
    logic             refusing_reg,    refusing_next;
    logic             power_reg,       power_next;
    logic             sending_reg,     sending_next;
    logic             boost_reg,       boost_next;

    // Store access and forwarding
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;
    logic [7:0]    cur_byte;

    // Result fields before the output register
    irsir_pkg::status_t status_c;
    logic             rxv_c, rxend_c, bitv_c, done_c;
    logic [7:0]       rxb_c;
    logic [CNT_W-1:0] rxlen_c;
    logic [TW-1:0]    rise_c, period_c;

    // Output register
    logic             m_valid_reg;
    logic [1:0]       status_reg;
    logic             rxv_reg, rxend_reg, bitv_reg, done_reg, boost_out_reg, active_reg;
    logic [7:0]       rxb_reg;
    logic [CNT_W-1:0] rxlen_reg;
    logic [TW-1:0]    rise_reg, period_reg;

    // Scratch values in the request logic
    logic [CNT_W-1:0] rx_inc;
    logic [FW-1:0]    frame_tmp;
    logic             rx_close;
    logic             cfg_fire, s_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign s_ready   = (!m_valid_reg || m_ready) && !cfg_valid;
    assign s_fire    = s_valid && s_ready;

    // Send store
    irsir_ram #(
        .WIDTH (8),
        .DEPTH (MSG_DEPTH)
    ) u_send_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_waddr = load_count_reg[AW-1:0];
    assign ram_raddr = send_index_next[AW-1:0];
    assign cur_byte  = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    // Write-to-read forwarding for the entry read in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else begin
            fwd_hit_reg <= ram_we && (ram_waddr == ram_raddr);
        end
        fwd_data_reg <= s_data_byte;
    end

    // Next state and result of a configuration write or a request
    always_comb begin
        send_length_next = send_length_reg;
        load_count_next  = load_count_reg;
        send_index_next  = send_index_reg;
        rx_count_next    = rx_count_reg;
        frame_next       = frame_reg;
        refusing_next    = refusing_reg;
        power_next       = power_reg;
        sending_next     = sending_reg;
        boost_next       = boost_reg;
        ram_we           = 1'b0;
        status_c         = irsir_pkg::ST_IGNORED;
        rxv_c            = 1'b0;
        rxb_c            = 8'd0;
        rxend_c          = 1'b0;
        rxlen_c          = '0;
        bitv_c           = 1'b0;
        rise_c           = '0;
        period_c         = '0;
        done_c           = 1'b0;
        rx_inc           = rx_count_reg + CNT_W'(1);
        frame_tmp        = frame_reg;
        rx_close         = 1'b0;

        if (cfg_fire) begin
            // Receiver switched off: drop partial message, start pending send
            if (cfg_index == irsir_pkg::CFG_RX_ENABLE && !cfg_data[0]) begin
                rx_count_next = '0;
                if (send_length_reg != '0 && !sending_reg) begin
                    sending_next    = 1'b1;
                    send_index_next = '0;
                    frame_next      = '0;
                    boost_next      = power_reg;
                end
            end
        end else if (s_fire) begin
            case (irsir_pkg::req_t'(s_req_type))
                irsir_pkg::REQ_SEND: begin
                    if (refusing_reg || (load_count_reg == '0 && send_length_reg != '0)) begin
                        status_c      = irsir_pkg::ST_BUSY;
                        refusing_next = !s_last_byte;
                    end else begin
                        if (load_count_reg < DEPTH_C) begin
                            ram_we          = 1'b1;
                            load_count_next = load_count_reg + CNT_W'(1);
                            status_c        = irsir_pkg::ST_OK;
                        end else begin
                            status_c = irsir_pkg::ST_OVERFLOW;
                        end
                        if (s_last_byte) begin
                            send_length_next = load_count_next;
                            load_count_next  = '0;
                            power_next       = s_high_power;
                            if (rx_count_reg == '0 && send_length_next != '0) begin
                                sending_next    = 1'b1;
                                send_index_next = '0;
                                frame_next      = '0;
                                boost_next      = s_high_power;
                            end
                        end
                    end
                end
                irsir_pkg::REQ_RX_BYTE, irsir_pkg::REQ_TIMEOUT: begin
                    if (!sending_reg && rx_enable_reg) begin
                        if (s_req_type == irsir_pkg::REQ_RX_BYTE) begin
                            status_c      = irsir_pkg::ST_OK;
                            rxv_c         = 1'b1;
                            rxb_c         = s_data_byte;
                            rx_count_next = rx_inc;
                            rx_close      = (rx_inc >= DEPTH_C) || (s_data_byte == end_byte_reg);
                        end else if (rx_count_reg != '0) begin
                            status_c = irsir_pkg::ST_OK;
                            rx_close = 1'b1;
                        end
                        // Close the received message, then start a pending send
                        if (rx_close) begin
                            rxend_c       = 1'b1;
                            rxlen_c       = rx_count_next;
                            rx_count_next = '0;
                            if (send_length_reg != '0) begin
                                sending_next    = 1'b1;
                                send_index_next = '0;
                                frame_next      = '0;
                                boost_next      = power_reg;
                            end
                        end
                    end
                end
                irsir_pkg::REQ_TICK: begin
                    if (sending_reg) begin
                        status_c = irsir_pkg::ST_OK;
                        // Load the next frame: start bit, data LSB first, stop bit
                        if (frame_reg == '0 && send_index_reg < send_length_reg
                                && send_index_reg < DEPTH_C) begin
                            frame_tmp       = {1'b1, cur_byte, 1'b0};
                            send_index_next = send_index_reg + CNT_W'(1);
                        end
                        bitv_c = 1'b1;
                        if (frame_tmp[0]) begin
                            rise_c   = one_rise_reg;
                            period_c = one_period_reg;
                        end else begin
                            rise_c   = zero_rise_reg;
                            period_c = zero_period_reg;
                        end
                        frame_next = frame_tmp >> 1;
                        // Last stop bit out: release the link
                        if (frame_next == '0 && send_index_next >= send_length_reg) begin
                            done_c           = 1'b1;
                            boost_next       = 1'b0;
                            send_length_next = '0;
                            sending_next     = 1'b0;
                            rx_count_next    = '0;
                        end
                    end
                end
                default: begin
                    status_c = irsir_pkg::ST_IGNORED;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_byte_reg    <= irsir_pkg::END_BYTE_RST;
            rx_enable_reg   <= 1'b1;
            zero_rise_reg   <= irsir_pkg::ZERO_RISE_RST;
            zero_period_reg <= irsir_pkg::ZERO_PERIOD_RST;
            one_rise_reg    <= irsir_pkg::ONE_RISE_RST;
            one_period_reg  <= irsir_pkg::ONE_PERIOD_RST;
        end else if (cfg_fire) begin
            case (cfg_index)
                irsir_pkg::CFG_END_BYTE:    end_byte_reg    <= cfg_data[7:0];
                irsir_pkg::CFG_RX_ENABLE:   rx_enable_reg   <= cfg_data[0];
                irsir_pkg::CFG_ZERO_RISE:   zero_rise_reg   <= cfg_data;
                irsir_pkg::CFG_ZERO_PERIOD: zero_period_reg <= cfg_data;
                irsir_pkg::CFG_ONE_RISE:    one_rise_reg    <= cfg_data;
                irsir_pkg::CFG_ONE_PERIOD:  one_period_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Link state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_length_reg <= '0;
            load_count_reg  <= '0;
            send_index_reg  <= '0;
            rx_count_reg    <= '0;
            frame_reg       <= '0;
            refusing_reg    <= 1'b0;
            power_reg       <= 1'b0;
            sending_reg     <= 1'b0;
            boost_reg       <= 1'b0;
        end else begin
            send_length_reg <= send_length_next;
            load_count_reg  <= load_count_next;
            send_index_reg  <= send_index_next;
            rx_count_reg    <= rx_count_next;
            frame_reg       <= frame_next;
            refusing_reg    <= refusing_next;
            power_reg       <= power_next;
            sending_reg     <= sending_next;
            boost_reg       <= boost_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (s_fire) begin
            status_reg    <= status_c;
            rxv_reg       <= rxv_c;
            rxb_reg       <= rxb_c;
            rxend_reg     <= rxend_c;
            rxlen_reg     <= rxlen_c;
            bitv_reg      <= bitv_c;
            rise_reg      <= rise_c;
            period_reg    <= period_c;
            done_reg      <= done_c;
            boost_out_reg <= boost_next;
            active_reg    <= sending_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_rx_byte_valid = rxv_reg;
    assign m_rx_byte       = rxb_reg;
    assign m_rx_msg_end    = rxend_reg;
    assign m_rx_length     = irsir_pkg::LEN_W'(rxlen_reg);
    assign m_bit_valid     = bitv_reg;
    assign m_rise_offset   = rise_reg;
    assign m_bit_period    = period_reg;
    assign m_tx_done       = done_reg;
    assign m_boost_on      = boost_out_reg;
    assign m_tx_active     = active_reg;

endmodule
